### design/tfr8_pkg.sv
// Package for the texel format to RGBA8 unit: payload structs, layout and
// data kind codes, configuration indexes. No dependencies.
`default_nettype none
package tfr8_pkg;

   // Layout codes, in register order; 27..31 are unsupported
   localparam logic [4:0] LAY_R4G4         = 5'd0;
   localparam logic [4:0] LAY_R8           = 5'd1;
   localparam logic [4:0] LAY_R8G8         = 5'd2;
   localparam logic [4:0] LAY_R8G8B8A8     = 5'd3;
   localparam logic [4:0] LAY_B8G8R8A8     = 5'd4;
   localparam logic [4:0] LAY_R4G4B4A4     = 5'd5;
   localparam logic [4:0] LAY_A4B4G4R4     = 5'd6;
   localparam logic [4:0] LAY_R5G5B5A1     = 5'd7;
   localparam logic [4:0] LAY_A1B5G5R5     = 5'd8;
   localparam logic [4:0] LAY_B5G5R5A1     = 5'd9;
   localparam logic [4:0] LAY_R5G6B5       = 5'd10;
   localparam logic [4:0] LAY_B5G6R5       = 5'd11;
   localparam logic [4:0] LAY_R16          = 5'd12;
   localparam logic [4:0] LAY_R16G16       = 5'd13;
   localparam logic [4:0] LAY_R16G16B16A16 = 5'd14;
   localparam logic [4:0] LAY_R32          = 5'd15;
   localparam logic [4:0] LAY_R32G32       = 5'd16;
   localparam logic [4:0] LAY_R32G32B32    = 5'd17;
   localparam logic [4:0] LAY_R32G32B32A32 = 5'd18;
   localparam logic [4:0] LAY_R24G8        = 5'd19;
   localparam logic [4:0] LAY_R32G8X24     = 5'd20;
   localparam logic [4:0] LAY_R10G10B10A2  = 5'd21;
   localparam logic [4:0] LAY_A2B10G10R10  = 5'd22;
   localparam logic [4:0] LAY_R11G11B10    = 5'd23;
   localparam logic [4:0] LAY_B10G11R11    = 5'd24;
   localparam logic [4:0] LAY_R10G11B11    = 5'd25;
   localparam logic [4:0] LAY_R9G9B9E5     = 5'd26;
   localparam logic [4:0] LAY_RESET        = LAY_R8G8B8A8;

   localparam logic [1:0] KIND_UNORM = 2'd0;
   localparam logic [1:0] KIND_SNORM = 2'd1;
   localparam logic [1:0] KIND_FLOAT = 2'd2;

   localparam logic CSR_LAYOUT = 1'b0;
   localparam logic CSR_KIND   = 1'b1;

   localparam int CSR_DATA_W = 5;

   typedef struct packed {
      logic [31:0] word0;
      logic [31:0] word1;
      logic [31:0] word2;
      logic [31:0] word3;
      logic        last_pixel;
   } req_payload_type;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [7:0] alpha;
      logic       format_error;
      logic       last_out;
   } rsp_payload_type;

endpackage
`default_nettype wire

### design/texel_format_to_rgba8_unit.sv
// Top level of the texel format to RGBA8 unit: decode, normalize setup and
// an eight-step restoring divider per channel. Depends on tfr8_pkg.
`default_nettype none
//
//  channel  direction  handshake            payload
//  req      in         req_valid/req_stall  req_payload (four words, last marker)
//  rsp      out        rsp_valid/rsp_stall  rsp_payload (RGBA bytes, error, last)
//  csr      in         csr_we               csr_index, csr_wdata
//
//  One transaction per cycle sustained while no result is held; the stages
//  are decode, numerator/denominator setup and eight quotient-bit stages.
//  Reset is synchronous and clears the stage valid bits and the registers
//  (layout R8G8B8A8, unsigned kind).
//  A stalled result freezes the whole pipe; req_stall follows that freeze.
//
module texel_format_to_rgba8_unit
   import tfr8_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output      logic                  req_stall,
   input  wire req_payload_type       req_payload,
   output      logic                  rsp_valid,
   input  wire logic                  rsp_stall,
   output      rsp_payload_type       rsp_payload,
   input  wire logic                  csr_we,
   input  wire logic                  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int NSTEP = 8;          // quotient bits (bytes are below 256)
   localparam int NSTG  = NSTEP + 2;  // decode + setup + divider steps

   localparam logic [1:0] CLS_FIN = 2'd0;
   localparam logic [1:0] CLS_INF = 2'd1;
   localparam logic [1:0] CLS_NAN = 2'd2;

   // Per-channel source: integer field (m masked to n bits) or float m*2^e
   typedef struct packed {
      logic               is_flt;
      logic [1:0]         cls;
      logic               neg;
      logic [31:0]        m;
      logic signed [8:0]  e;
      logic [5:0]         n;
      logic               sgn;
      logic               mp;   // map v/2+1/2
   } chan_src_type;

   // Divider state: byte = floor(num/den); direct bytes ride in q, rem 0
   typedef struct packed {
      logic [47:0] rem;
      logic [40:0] den;
      logic [7:0]  q;
   } div_type;

   function automatic chan_src_type mk_int(logic [31:0] r, logic [5:0] n,
                                           logic sgn, logic mp);
      chan_src_type s;
      s = '0;
      s.m = r; s.n = n; s.sgn = sgn; s.mp = mp;
      return s;
   endfunction

   function automatic chan_src_type mk_fl(logic [1:0] cls, logic neg, logic [31:0] m,
                                          logic signed [8:0] e, logic mp);
      chan_src_type s;
      s = '0;
      s.is_flt = 1'b1; s.cls = cls; s.neg = neg; s.m = m; s.e = e; s.mp = mp;
      return s;
   endfunction

   function automatic chan_src_type mk_half(logic [15:0] h, logic mp);
      logic [4:0] ex;
      chan_src_type s;
      ex = h[14:10];
      if (ex == 5'd31)
         s = mk_fl((h[9:0] != 10'd0) ? CLS_NAN : CLS_INF, h[15], '0, '0, mp);
      else if (ex == 5'd0)
         s = mk_fl(CLS_FIN, h[15], {22'd0, h[9:0]}, -9'sd24, mp);
      else
         s = mk_fl(CLS_FIN, h[15], {21'd0, 1'b1, h[9:0]},
                   $signed({4'd0, ex}) - 9'sd25, mp);
      return s;
   endfunction

   function automatic chan_src_type mk_f32(logic [31:0] w, logic mp);
      logic [7:0] ex;
      chan_src_type s;
      ex = w[30:23];
      if (ex == 8'd255)
         s = mk_fl((w[22:0] != 23'd0) ? CLS_NAN : CLS_INF, w[31], '0, '0, mp);
      else if (ex == 8'd0)
         s = mk_fl(CLS_FIN, w[31], {9'd0, w[22:0]}, -9'sd149, mp);
      else
         s = mk_fl(CLS_FIN, w[31], {8'd0, 1'b1, w[22:0]},
                   $signed({1'b0, ex}) - 9'sd150, mp);
      return s;
   endfunction

   // unsigned small float, 5-bit exponent, 6- or 5-bit mantissa
   function automatic chan_src_type mk_small(logic [10:0] raw, logic six, logic mp);
      logic [5:0]  mt;
      logic [4:0]  ex;
      logic [31:0] lead;
      chan_src_type s;
      mt   = six ? raw[5:0] : {1'b0, raw[4:0]};
      ex   = six ? raw[10:6] : raw[9:5];
      lead = six ? 32'd64 : 32'd32;
      if (ex == 5'd0)
         s = mk_fl(CLS_FIN, 1'b0, {26'd0, mt}, six ? -9'sd20 : -9'sd19, mp);
      else if (ex == 5'd31)
         s = mk_fl(CLS_FIN, 1'b0, (mt != 6'd0) ? 32'd0 : 32'd1, '0, mp);
      else
         s = mk_fl(CLS_FIN, 1'b0, lead + {26'd0, mt},
                   $signed({4'd0, ex}) - (six ? 9'sd21 : 9'sd20), mp);
      return s;
   endfunction

   function automatic div_type prep(chan_src_type s);
      logic [32:0] full, d, half, rx;
      logic [33:0] a;
      logic [47:0] num, m255;
      logic [40:0] den;
      logic [8:0]  k;
      logic        dir;
      logic [7:0]  db;
      div_type     o;
      dir = 1'b0; db = '0; num = '0; den = 41'd1;
      full = '0; d = '0; half = '0; rx = '0; a = '0;
      k = 9'(-s.e);
      m255 = (48'(s.m) << 8) - 48'(s.m);
      if (!s.is_flt) begin
         full = (33'd1 << s.n) - 33'd1;
         rx   = {1'b0, s.m} & full;
         if (s.sgn) begin
            half = 33'd1 << (s.n - 6'd1);
            d    = half - 33'd1;
         end else begin
            d = full;
         end
         a = s.mp ? (34'(rx) + 34'(d)) : {rx, 1'b0};
         if (s.sgn && ((rx & half) != 33'd0)) begin
            // negative: floor at -1
            if (!s.mp) begin
               dir = 1'b1; db = 8'd0;
            end else begin
               a = (rx > half) ? 34'(rx - half - 33'd1) : 34'd0;
            end
         end
         num = (48'(a) << 8) - 48'(a) + 48'(d);
         den = 41'({d, 1'b0});
      end else if (s.cls == CLS_NAN) begin
         dir = 1'b1; db = 8'd0;
      end else if (s.cls == CLS_INF) begin
         dir = 1'b1; db = s.neg ? 8'd0 : 8'd255;
      end else if (s.m == 32'd0) begin
         dir = 1'b1; db = s.mp ? 8'd128 : 8'd0;
      end else if (!s.e[8]) begin
         dir = 1'b1; db = s.neg ? 8'd0 : 8'd255;
      end else if (k < 9'd32 && (s.m >> k[4:0]) != 32'd0) begin
         dir = 1'b1; db = s.neg ? 8'd0 : 8'd255;
      end else if (!s.mp && (s.neg || k >= 9'd40)) begin
         dir = 1'b1; db = 8'd0;
      end else if (s.mp && k >= 9'd40) begin
         dir = 1'b1; db = s.neg ? 8'd127 : 8'd128;
      end else begin
         den = 41'd1 << (k[5:0] + 6'd1);
         if (!s.mp)
            num = (48'(s.m) << 9) - (48'(s.m) << 1) + (48'd1 << k[5:0]);
         else if (s.neg)
            num = (48'd1 << (k[5:0] + 6'd8)) - m255;
         else
            num = (48'd1 << (k[5:0] + 6'd8)) + m255;
      end
      if (dir) begin
         o.rem = '0; o.den = 41'd1; o.q = db;
      end else begin
         o.rem = num; o.den = den; o.q = '0;
      end
      return o;
   endfunction

   // configuration registers
   logic [4:0] layout_ff;
   logic [1:0] kind_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         layout_ff <= LAY_RESET;
         kind_ff   <= KIND_UNORM;
      end else if (csr_we) begin
         case (csr_index)
            CSR_LAYOUT: layout_ff <= csr_wdata[4:0];
            CSR_KIND:   kind_ff   <= csr_wdata[1:0];
            default:    ;
         endcase
      end
   end

   // pipe control: everything moves together unless the result is held
   logic            adv;
   logic [NSTG-1:0] vld_ff, err_ff, last_ff;
   logic            err_in;

   assign adv       = !(vld_ff[NSTG-1] && rsp_stall);
   assign req_stall = !adv;

   // stage 0: unpack the texel per layout
   chan_src_type src_in [4];
   chan_src_type src_ff [4];

   always_comb begin
      logic [31:0] w [4];
      logic        sg, fl, mp;
      logic [2:0]  cnt;
      w[0] = req_payload.word0; w[1] = req_payload.word1;
      w[2] = req_payload.word2; w[3] = req_payload.word3;
      sg = kind_ff == KIND_SNORM;
      fl = kind_ff == KIND_FLOAT;
      mp = sg;
      cnt = '0;
      err_in = 1'b0;
      for (int i = 0; i < 3; i++) src_in[i] = mk_int(32'd0, 6'd1, 1'b0, mp);
      src_in[3] = mk_int(32'd1, 6'd1, 1'b0, 1'b0);   // alpha defaults to 1
      case (layout_ff)
         LAY_R4G4: begin
            src_in[0] = mk_int(w[0], 6'd4, 1'b0, mp);
            src_in[1] = mk_int(w[0] >> 4, 6'd4, 1'b0, mp);
         end
         LAY_R8: src_in[0] = mk_int(w[0], 6'd8, sg, mp);
         LAY_R8G8: begin
            src_in[0] = mk_int(w[0], 6'd8, sg, mp);
            src_in[1] = mk_int(w[0] >> 8, 6'd8, sg, mp);
         end
         LAY_R8G8B8A8: begin
            src_in[0] = mk_int(w[0], 6'd8, sg, mp);
            src_in[1] = mk_int(w[0] >> 8, 6'd8, sg, mp);
            src_in[2] = mk_int(w[0] >> 16, 6'd8, sg, mp);
            src_in[3] = mk_int(w[0] >> 24, 6'd8, sg, 1'b0);
         end
         LAY_B8G8R8A8: begin
            src_in[0] = mk_int(w[0] >> 16, 6'd8, sg, mp);
            src_in[1] = mk_int(w[0] >> 8, 6'd8, sg, mp);
            src_in[2] = mk_int(w[0], 6'd8, sg, mp);
            src_in[3] = mk_int(w[0] >> 24, 6'd8, sg, 1'b0);
         end
         LAY_R4G4B4A4: begin
            src_in[0] = mk_int(w[0], 6'd4, 1'b0, mp);
            src_in[1] = mk_int(w[0] >> 4, 6'd4, 1'b0, mp);
            src_in[2] = mk_int(w[0] >> 8, 6'd4, 1'b0, mp);
            src_in[3] = mk_int(w[0] >> 12, 6'd4, 1'b0, 1'b0);
         end
         LAY_A4B4G4R4: begin
            src_in[3] = mk_int(w[0], 6'd4, 1'b0, 1'b0);
            src_in[2] = mk_int(w[0] >> 4, 6'd4, 1'b0, mp);
            src_in[1] = mk_int(w[0] >> 8, 6'd4, 1'b0, mp);
            src_in[0] = mk_int(w[0] >> 12, 6'd4, 1'b0, mp);
         end
         LAY_R5G5B5A1: begin
            src_in[0] = mk_int(w[0], 6'd5, 1'b0, mp);
            src_in[1] = mk_int(w[0] >> 5, 6'd5, 1'b0, mp);
            src_in[2] = mk_int(w[0] >> 10, 6'd5, 1'b0, mp);
            src_in[3] = mk_int(w[0] >> 15, 6'd1, 1'b0, 1'b0);
         end
         LAY_A1B5G5R5: begin
            src_in[3] = mk_int(w[0], 6'd1, 1'b0, 1'b0);
            src_in[2] = mk_int(w[0] >> 1, 6'd5, 1'b0, mp);
            src_in[1] = mk_int(w[0] >> 6, 6'd5, 1'b0, mp);
            src_in[0] = mk_int(w[0] >> 11, 6'd5, 1'b0, mp);
         end
         LAY_B5G5R5A1: begin
            src_in[2] = mk_int(w[0], 6'd5, 1'b0, mp);
            src_in[1] = mk_int(w[0] >> 5, 6'd5, 1'b0, mp);
            src_in[0] = mk_int(w[0] >> 10, 6'd5, 1'b0, mp);
            src_in[3] = mk_int(w[0] >> 15, 6'd1, 1'b0, 1'b0);
         end
         LAY_R5G6B5: begin
            src_in[0] = mk_int(w[0], 6'd5, 1'b0, mp);
            src_in[1] = mk_int(w[0] >> 5, 6'd6, 1'b0, mp);
            src_in[2] = mk_int(w[0] >> 11, 6'd5, 1'b0, mp);
         end
         LAY_B5G6R5: begin
            src_in[2] = mk_int(w[0], 6'd5, 1'b0, mp);
            src_in[1] = mk_int(w[0] >> 5, 6'd6, 1'b0, mp);
            src_in[0] = mk_int(w[0] >> 11, 6'd5, 1'b0, mp);
         end
         LAY_R16, LAY_R16G16, LAY_R16G16B16A16: begin
            cnt = (layout_ff == LAY_R16) ? 3'd1 :
                  ((layout_ff == LAY_R16G16) ? 3'd2 : 3'd4);
            for (int i = 0; i < 4; i++) begin
               if (3'(i) < cnt) begin
                  if (fl)
                     src_in[i] = mk_half(w[i/2][16*(i%2) +: 16], (i < 3) ? mp : 1'b0);
                  else
                     src_in[i] = mk_int({16'd0, w[i/2][16*(i%2) +: 16]}, 6'd16, sg,
                                        (i < 3) ? mp : 1'b0);
               end
            end
         end
         LAY_R32, LAY_R32G32, LAY_R32G32B32, LAY_R32G32B32A32: begin
            cnt = 3'(layout_ff - LAY_R16G16B16A16);
            for (int i = 0; i < 4; i++) begin
               if (3'(i) < cnt) begin
                  if (fl)
                     src_in[i] = mk_f32(w[i], (i < 3) ? mp : 1'b0);
                  else
                     src_in[i] = mk_int(w[i], 6'd32, sg, (i < 3) ? mp : 1'b0);
               end
            end
         end
         LAY_R24G8: begin
            src_in[0] = mk_int(w[0], 6'd24, 1'b0, mp);
            src_in[1] = mk_int(w[0] >> 24, 6'd8, 1'b0, mp);
         end
         LAY_R32G8X24: begin
            src_in[0] = mk_f32(w[0], mp);
            src_in[1] = mk_int(w[1], 6'd8, 1'b0, mp);
         end
         LAY_R10G10B10A2: begin
            src_in[0] = mk_int(w[0], 6'd10, sg, mp);
            src_in[1] = mk_int(w[0] >> 10, 6'd10, sg, mp);
            src_in[2] = mk_int(w[0] >> 20, 6'd10, sg, mp);
            src_in[3] = mk_int(w[0] >> 30, 6'd2, 1'b0, 1'b0);
         end
         LAY_A2B10G10R10: begin
            src_in[3] = mk_int(w[0], 6'd2, 1'b0, 1'b0);
            src_in[2] = mk_int(w[0] >> 2, 6'd10, sg, mp);
            src_in[1] = mk_int(w[0] >> 12, 6'd10, sg, mp);
            src_in[0] = mk_int(w[0] >> 22, 6'd10, sg, mp);
         end
         LAY_R11G11B10: begin
            src_in[0] = mk_small(w[0][10:0], 1'b1, mp);
            src_in[1] = mk_small(w[0][21:11], 1'b1, mp);
            src_in[2] = mk_small({1'b0, w[0][31:22]}, 1'b0, mp);
         end
         LAY_B10G11R11: begin
            src_in[2] = mk_small({1'b0, w[0][9:0]}, 1'b0, mp);
            src_in[1] = mk_small(w[0][20:10], 1'b1, mp);
            src_in[0] = mk_small(w[0][31:21], 1'b1, mp);
         end
         LAY_R10G11B11: begin
            src_in[0] = mk_small({1'b0, w[0][9:0]}, 1'b0, mp);
            src_in[1] = mk_small(w[0][20:10], 1'b1, mp);
            src_in[2] = mk_small(w[0][31:21], 1'b1, mp);
         end
         LAY_R9G9B9E5: begin
            // shared exponent, bias 15 plus 9 mantissa bits
            for (int i = 0; i < 3; i++)
               src_in[i] = mk_fl(CLS_FIN, 1'b0, {23'd0, w[0][9*i +: 9]},
                                 $signed({4'd0, w[0][31:27]}) - 9'sd24, mp);
         end
         default: begin
            // unsupported layout: all bytes zero, flag raised
            err_in = 1'b1;
            for (int i = 0; i < 4; i++) src_in[i] = mk_int(32'd0, 6'd1, 1'b0, 1'b0);
         end
      endcase
   end

   // divider stages: div_ff[0] holds num/den, div_ff[j] has quotient bits done
   div_type div_ff [NSTEP+1][4];
   div_type div_in [NSTEP+1][4];

   always_comb begin
      logic [47:0] sh;
      for (int c = 0; c < 4; c++) div_in[0][c] = prep(src_ff[c]);
      for (int j = 1; j <= NSTEP; j++) begin
         for (int c = 0; c < 4; c++) begin
            div_in[j][c] = div_ff[j-1][c];
            sh = 48'(div_ff[j-1][c].den) << (NSTEP - j);
            if (div_ff[j-1][c].rem >= sh) begin
               div_in[j][c].rem = div_ff[j-1][c].rem - sh;
               div_in[j][c].q[NSTEP-j] = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[NSTG-2:0], req_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         err_ff  <= {err_ff[NSTG-2:0], err_in};
         last_ff <= {last_ff[NSTG-2:0], req_payload.last_pixel};
         src_ff  <= src_in;
         div_ff  <= div_in;
      end
   end

   assign rsp_valid                = vld_ff[NSTG-1];
   assign rsp_payload.red          = div_ff[NSTEP][0].q;
   assign rsp_payload.green        = div_ff[NSTEP][1].q;
   assign rsp_payload.blue         = div_ff[NSTEP][2].q;
   assign rsp_payload.alpha        = div_ff[NSTEP][3].q;
   assign rsp_payload.format_error = err_ff[NSTG-1];
   assign rsp_payload.last_out     = last_ff[NSTG-1];

   // error transactions carry zero bytes
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.format_error |->
         rsp_payload.red == 8'd0 && rsp_payload.alpha == 8'd0)
      else $error("error transaction with nonzero bytes");

   // finished divide leaves a remainder below the divisor
   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> div_ff[NSTEP][0].rem < 48'(div_ff[NSTEP][0].den))
      else $error("red divide did not converge");

   // a frozen pipe keeps its occupancy
   a_freeze: assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(vld_ff))
      else $error("pipe moved while result held");

endmodule
`default_nettype wire
